// ----- hw/rtl/abtb_pkg.sv -----
// Package for the ASCII bit-text to bytes unit.
// Holds character codes, status codes, the character class and result types.
// No dependencies.
`default_nettype none

package abtb_pkg;

  localparam int WORD_BYTES_DEF = 2;
  localparam int BYTE_W         = 8;
  localparam int CNT_W          = 16;
  localparam int TOTAL_W        = 32;
  localparam int OUT_DATA_W     = 80;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SEP   = 2'd1,
    ST_BAD_CHAR = 2'd2,
    ST_HALTED   = 2'd3
  } status_t;

  typedef struct packed {
    logic is_sep;
    logic is_newline;
    logic is_comment;
    logic is_bit;
    logic bit_val;
  } char_class_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] bytes_written;
    logic [CNT_W-1:0]   column_number;
    logic [CNT_W-1:0]   line_number;
    status_t            status;
    logic [BYTE_W-1:0]  byte_value;
    logic               byte_valid;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/abtb_class.sv -----
// Character classifier for the ASCII bit-text to bytes unit.
// Sorts one character into separator, newline, comment opener or bit digit.
// Depends on abtb_pkg.
`default_nettype none

module abtb_class
  import abtb_pkg::*;
(
  input  wire logic [7:0]  char_code,
  output char_class_t      cls
);

  always_comb begin
    cls.is_sep     = (char_code == CH_TAB) || (char_code == CH_SPACE) ||
                     (char_code == CH_CR) || (char_code == CH_DOT) ||
                     (char_code == CH_UNDER);
    cls.is_newline = (char_code == CH_LF);
    cls.is_comment = (char_code == CH_SEMI) || (char_code == CH_HASH);
    cls.is_bit     = (char_code == CH_ZERO) || (char_code == CH_ONE);
    cls.bit_val    = char_code[0];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/abtb_core.sv -----
// Parser state and next-state logic for the ASCII bit-text to bytes unit.
// Updates counters, the partial byte and the error state on each beat.
// Depends on abtb_pkg.
`default_nettype none

module abtb_core
  import abtb_pkg::*;
#(
  parameter int WORD_BYTES = WORD_BYTES_DEF
)
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,
  input  char_class_t cls,
  output result_t    res
);

  localparam int PH_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(WORD_BYTES - 1);

  logic               in_comment_r, in_comment_nxt;
  logic               wss_r, wss_nxt;
  logic [2:0]         bit_count_r, bit_count_nxt;
  logic [BYTE_W-1:0]  partial_r, partial_nxt;
  logic [PH_W-1:0]    phase_r, phase_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]   line_r, line_nxt;
  logic [CNT_W-1:0]   col_r, col_nxt;
  logic               halted_r, halted_nxt;
  logic [BYTE_W-1:0]  merged;
  logic [CNT_W-1:0]   col_inc;
  logic [CNT_W-1:0]   line_inc;

  always_comb begin
    merged   = partial_r | ({{(BYTE_W-1){1'b0}}, cls.bit_val} << (3'd7 - bit_count_r));
    col_inc  = (col_r == '1) ? col_r : col_r + 1'b1;
    line_inc = (line_r == '1) ? line_r : line_r + 1'b1;

    in_comment_nxt = in_comment_r;
    wss_nxt        = wss_r;
    bit_count_nxt  = bit_count_r;
    partial_nxt    = partial_r;
    phase_nxt      = phase_r;
    total_nxt      = total_r;
    line_nxt       = line_r;
    col_nxt        = col_r;
    halted_nxt     = halted_r;

    res.byte_valid    = 1'b0;
    res.byte_value    = '0;
    res.status        = ST_OK;
    res.line_number   = line_r;
    res.column_number = col_r;

    if (halted_r) begin
      res.status = ST_HALTED;
    end else if (cls.is_sep) begin
      wss_nxt = 1'b1;
      col_nxt = col_inc;
    end else if (cls.is_newline) begin
      wss_nxt        = 1'b1;
      in_comment_nxt = 1'b0;
      line_nxt       = line_inc;
      col_nxt        = CNT_W'(1);
    end else if (in_comment_r) begin
      col_nxt = col_inc;
    end else if ((phase_r == '0) && (bit_count_r == 3'd0) && !wss_r) begin
      res.status = ST_NO_SEP;
      halted_nxt = 1'b1;
    end else if (cls.is_comment) begin
      in_comment_nxt = 1'b1;
      col_nxt        = col_inc;
    end else if (cls.is_bit) begin
      wss_nxt = 1'b0;
      col_nxt = col_inc;
      if (bit_count_r == 3'd7) begin
        res.byte_valid = 1'b1;
        res.byte_value = merged;
        partial_nxt    = '0;
        bit_count_nxt  = 3'd0;
        total_nxt      = (total_r == '1) ? total_r : total_r + 1'b1;
        phase_nxt      = (phase_r == PH_LAST) ? '0 : phase_r + 1'b1;
      end else begin
        partial_nxt   = merged;
        bit_count_nxt = bit_count_r + 3'd1;
      end
    end else begin
      res.status = ST_BAD_CHAR;
      halted_nxt = 1'b1;
    end

    res.bytes_written = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_comment_r <= 1'b0;
      wss_r        <= 1'b1;
      bit_count_r  <= 3'd0;
      partial_r    <= '0;
      phase_r      <= '0;
      total_r      <= '0;
      line_r       <= CNT_W'(1);
      col_r        <= CNT_W'(1);
      halted_r     <= 1'b0;
    end else if (step) begin
      in_comment_r <= in_comment_nxt;
      wss_r        <= wss_nxt;
      bit_count_r  <= bit_count_nxt;
      partial_r    <= partial_nxt;
      phase_r      <= phase_nxt;
      total_r      <= total_nxt;
      line_r       <= line_nxt;
      col_r        <= col_nxt;
      halted_r     <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ascii_bit_text_to_bytes_unit.sv -----
// Top level of the ASCII bit-text to bytes unit.
// Instantiates abtb_class and abtb_core and holds the result register.
// Depends on abtb_pkg.
`default_nettype none

// The unit takes one text character per input beat and returns exactly one
// result beat for it, carrying the completed byte if any, a status code, the
// character's line and column, and the running byte count. A character is
// accepted in every cycle in which the result register is empty or being
// drained, so the sustained rate is one character per clock; the result
// register presents the result beat in the cycle after the character is
// accepted. After an error the unit answers every further character with
// the halted status until reset.

module ascii_bit_text_to_bytes_unit
  import abtb_pkg::*;
#(
  parameter int WORD_BYTES = WORD_BYTES_DEF
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // char_code[7:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // byte_valid[0], byte_value[8:1],
                                                 // status[10:9], line_number[26:11],
                                                 // column_number[42:27],
                                                 // bytes_written[74:43], zero pad
);

  char_class_t cls;
  result_t     res;
  result_t     res_r;
  logic        out_valid_r;
  logic        accept;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  abtb_class u_class (
    .char_code (in_tdata),
    .cls       (cls)
  );

  abtb_core #(
    .WORD_BYTES (WORD_BYTES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .cls   (cls),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), res_r};

endmodule

`default_nettype wire

// ----- bench/ascii_bit_text_to_bytes_unit_tb.sv -----
// Self-checking testbench for ascii_bit_text_to_bytes_unit: random stream traffic with a
// scoreboard class that predicts every result beat from the accepted characters.
// Depends on abtb_pkg and the unit's RTL.
`timescale 1ns / 1ps

module ascii_bit_text_to_bytes_unit_tb;
  import abtb_pkg::*;

  localparam int WB        = WORD_BYTES_DEF;
  localparam int RES_W     = $bits(result_t);
  localparam int MAX_CYCLE = 1500000;

  class text_decoder_board;
    bit          in_comment;
    bit          word_start;
    bit          halted;
    logic [2:0]  bit_cnt;
    logic [7:0]  part;
    int unsigned phase;
    logic [31:0] total;
    logic [15:0] line;
    logic [15:0] col;
    result_t     pending_results[$];
    int          errors;
    int          checked;
    int          assembled;

    function new();
      in_comment = 0;
      word_start = 1;
      halted     = 0;
      bit_cnt    = '0;
      part       = '0;
      phase      = 0;
      total      = '0;
      line       = 16'd1;
      col        = 16'd1;
      errors     = 0;
      checked    = 0;
      assembled  = 0;
    endfunction

    function logic [15:0] sat16(logic [15:0] x);
      return (x == 16'hFFFF) ? x : x + 16'd1;
    endfunction

    function result_t decode(logic [7:0] ch, bit commit);
      result_t     r;
      bit          ic, ws, hl;
      logic [2:0]  bc;
      logic [7:0]  pb;
      int unsigned ph;
      logic [31:0] tot;
      logic [15:0] ln, cl;
      ic = in_comment; ws = word_start; hl = halted;
      bc = bit_cnt; pb = part; ph = phase; tot = total; ln = line; cl = col;
      r = '0;
      r.status = ST_OK;
      r.line_number = ln;
      r.column_number = cl;
      if (hl) begin
        r.status = ST_HALTED;
      end else if (ch inside {CH_TAB, CH_SPACE, CH_CR, CH_DOT, CH_UNDER}) begin
        ws = 1;
        cl = sat16(cl);
      end else if (ch == CH_LF) begin
        ws = 1;
        ic = 0;
        ln = sat16(ln);
        cl = 16'd1;
      end else if (ic) begin
        cl = sat16(cl);
      end else if (ph == 0 && bc == 3'd0 && !ws) begin
        r.status = ST_NO_SEP;
        hl = 1;
      end else if (ch == CH_SEMI || ch == CH_HASH) begin
        ic = 1;
        cl = sat16(cl);
      end else if (ch == CH_ZERO || ch == CH_ONE) begin
        pb = pb | (8'(ch[0]) << (3'd7 - bc));
        ws = 0;
        cl = sat16(cl);
        if (bc == 3'd7) begin
          r.byte_valid = 1'b1;
          r.byte_value = pb;
          pb = '0;
          bc = '0;
          if (tot != 32'hFFFF_FFFF) tot = tot + 32'd1;
          ph = (ph + 1) % WB;
        end else begin
          bc = bc + 3'd1;
        end
      end else begin
        r.status = ST_BAD_CHAR;
        hl = 1;
      end
      r.bytes_written = tot;
      if (commit) begin
        in_comment = ic; word_start = ws; halted = hl;
        bit_cnt = bc; part = pb; phase = ph; total = tot; line = ln; col = cl;
      end
      return r;
    endfunction

    function bit is_safe(logic [7:0] ch);
      result_t r;
      r = decode(ch, 0);
      return r.status == ST_OK;
    endfunction

    function void note_char(logic [7:0] ch);
      result_t r;
      r = decode(ch, 1);
      if (r.byte_valid) assembled++;
      pending_results.push_back(r);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void mismatch(string name, longint unsigned e, longint unsigned a);
      errors++;
      if (errors <= 40) $error("%s mismatch: expected %0h, actual %0h", name, e, a);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      result_t e, a;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 40) $error("result beat with no character pending: %h", d);
        return;
      end
      e = pending_results.pop_front();
      a = result_t'(d[RES_W-1:0]);
      checked++;
      if (a.byte_valid !== e.byte_valid) mismatch("byte_valid", e.byte_valid, a.byte_valid);
      if (a.byte_value !== e.byte_value) mismatch("byte_value", e.byte_value, a.byte_value);
      if (a.status !== e.status) mismatch("status", e.status, a.status);
      if (a.line_number !== e.line_number)
        mismatch("line_number", e.line_number, a.line_number);
      if (a.column_number !== e.column_number)
        mismatch("column_number", e.column_number, a.column_number);
      if (a.bytes_written !== e.bytes_written)
        mismatch("bytes_written", e.bytes_written, a.bytes_written);
      if (d[OUT_DATA_W-1:RES_W] !== '0) mismatch("pad", 0, d[OUT_DATA_W-1:RES_W]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // char_code[7:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // byte_valid[0], byte_value[8:1], status[10:9],
                                          // line_number[26:11], column_number[42:27],
                                          // bytes_written[74:43], zero pad

  text_decoder_board sb = new();
  bit     no_idle = 0;
  int     cycles = 0;
  int     chars = 0;
  string  ending;

  ascii_bit_text_to_bytes_unit #(.WORD_BYTES(WB)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_char(logic [7:0] ch);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    do @(posedge clk); while (!in_tready);
    sb.note_char(ch);
    chars++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_char();
    int         r;
    logic [7:0] ch;
    r = $urandom_range(0, 99);
    if (sb.in_comment) begin
      ch = (r < 10) ? CH_LF : 8'($urandom_range(0, 255));
    end else if (r < 55) begin
      ch = $urandom_range(0, 1) ? CH_ONE : CH_ZERO;
    end else if (r < 70) begin
      case ($urandom_range(0, 4))
        0: ch = CH_TAB;
        1: ch = CH_SPACE;
        2: ch = CH_CR;
        3: ch = CH_DOT;
        default: ch = CH_UNDER;
      endcase
    end else if (r < 77) begin
      ch = CH_LF;
    end else if (r < 83) begin
      ch = $urandom_range(0, 1) ? CH_SEMI : CH_HASH;
    end else begin
      ch = 8'($urandom_range(0, 255));
    end
    if (!sb.is_safe(ch)) ch = CH_SPACE;
    return ch;
  endfunction

  initial begin
    logic [7:0] dir_q[$];
    logic [7:0] ch;
    bit         want_no_sep;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_q.push_back(CH_TAB);
    repeat (8) dir_q.push_back(CH_ONE);
    dir_q.push_back(CH_UNDER);
    repeat (8) dir_q.push_back(CH_ZERO);
    dir_q = {dir_q, CH_DOT, CH_SEMI, 8'hFF, 8'h80, 8'h00, CH_LF, CH_SPACE, CH_HASH,
             8'h41, CH_LF, CH_CR, CH_ZERO, CH_ONE};
    foreach (dir_q[i]) send_char(dir_q[i]);

    for (int i = 0; i < 800; i++) begin
      if (i == 400) drain();
      no_idle = (i >= 550 && i < 650);
      send_char(random_char());
    end

    send_char(CH_LF);
    want_no_sep = $urandom_range(0, 1);
    if (want_no_sep) begin
      while (!(sb.phase == 0 && sb.bit_cnt == 3'd0 && !sb.word_start))
        send_char($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
      case ($urandom_range(0, 3))
        0: ch = $urandom_range(0, 1) ? CH_ONE : CH_ZERO;
        1: ch = CH_SEMI;
        2: ch = CH_HASH;
        default: begin
          do ch = 8'($urandom_range(0, 255));
          while (ch inside {CH_TAB, CH_SPACE, CH_CR, CH_DOT, CH_UNDER, CH_LF});
        end
      endcase
      ending = "missing separator";
    end else begin
      do ch = 8'($urandom_range(0, 255)); while (sb.is_safe(ch));
      ending = "invalid character";
    end
    send_char(ch);
    repeat (5) send_char(8'($urandom_range(0, 255)));

    drain();
    repeat (4) @(posedge clk);
    $display("Checked %0d result beats from %0d characters, %0d bytes assembled.",
             sb.checked, chars, sb.assembled);
    $display("Separators, comments, stalls and a full drain were exercised; %s error last.",
             ending);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
